@@ src/iqmh_pkg.sv @@
// Package for the indexed 4-ary min-heap: sizes, item types, status and action codes,
// controller states and the command/status structs between controller and datapath.
package iqmh_pkg;

    localparam int CAPACITY  = 256;
    localparam int ARITY     = 4;
    localparam int TAG_COUNT = 256;
    localparam int PW = $clog2(CAPACITY);      // slot index bits
    localparam int CW = $clog2(CAPACITY + 1);  // count bits
    localparam int TW = $clog2(TAG_COUNT);
    localparam int AW = $clog2(ARITY);
    localparam int XW = PW + AW + 1;           // child index bits

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;  // unused action, answers ok

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         tag;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         out_tag;
        logic signed [31:0] out_key;
        logic [8:0]         count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_POP_LD, S_DN_RD, S_UP_RD, S_UP_CMP, S_DONE
    } t_state;

    // Datapath operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE, OP_LOOK, OP_STATUS, OP_INS, OP_POP, OP_POP_LD, OP_UPD,
        OP_DN_RD, OP_DN_SWAP, OP_UP_RD, OP_UP_SWAP, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       tag_hit;    // tag present in heap
        logic       full;
        logic       empty;
        logic       last_pop;   // pop leaves heap empty
        logic       rd_busy;    // child reads still pending
        logic       dn_stay;    // no child smaller
        logic       at_root;    // moving entry sits in slot zero
        logic       up_stop;    // parent not larger
    } t_stat;

endpackage

@@ src/iqmh_ctrl.sv @@
// Controller state machine of the heap: sequences lookup, sifts and the result.
// Depends on iqmh_pkg.
module iqmh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_free,
    input  iqmh_pkg::t_stat i_stat,
    output iqmh_pkg::t_cmd  o_cmd
);
    import iqmh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOOK;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (i_stat.action)
                    ACT_INSERT: begin
                        if (i_stat.tag_hit) begin
                            o_cmd.op = OP_STATUS; o_cmd.status = ST_PRESENT;
                        end else if (i_stat.full) begin
                            o_cmd.op = OP_STATUS; o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.op = OP_INS;
                            n_state  = S_UP_RD;
                        end
                    end
                    ACT_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.op = OP_STATUS; o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.op = OP_POP;
                            n_state  = i_stat.last_pop ? S_DONE : S_POP_LD;
                        end
                    end
                    ACT_UPDATE: begin
                        if (!i_stat.tag_hit) begin
                            o_cmd.op = OP_STATUS; o_cmd.status = ST_ABSENT;
                        end else begin
                            o_cmd.op = OP_UPD;
                            n_state  = S_DN_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_POP_LD: begin
                o_cmd.op = OP_POP_LD;
                n_state  = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_stat.rd_busy) o_cmd.op = OP_DN_RD;
                else if (i_stat.dn_stay) begin
                    n_state = (i_stat.action == ACT_UPDATE) ? S_UP_RD : S_DONE;
                end else o_cmd.op = OP_DN_SWAP;
            end
            S_UP_RD: begin
                if (i_stat.at_root) n_state = S_DONE;
                else begin
                    o_cmd.op = OP_UP_RD;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_stop) n_state = S_DONE;
                else begin
                    o_cmd.op = OP_UP_SWAP;
                    n_state  = S_UP_RD;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The state sequence never skips decision after a new item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_DECIDE)
        else $error("no decide after accept");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP && !i_stat.up_stop) |=> r_state == S_UP_RD)
        else $error("sift up lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");
endmodule

@@ src/iqmh_dp.sv @@
// Datapath of the heap: slot memories, tag position table, count, sift registers
// and the result register. Depends on iqmh_pkg.
module iqmh_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iqmh_pkg::t_in_item  i_in_item,
    input  iqmh_pkg::t_cmd      i_cmd,
    output iqmh_pkg::t_stat     o_stat,
    output logic                o_out_free,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output iqmh_pkg::t_out_item o_out_item
);
    import iqmh_pkg::*;

    // Slot memory: one write and one read port, registered read.
    logic [TW+31:0] mem_slot [CAPACITY];
    logic [PW-1:0]  pos_mem  [TAG_COUNT];
    logic [TAG_COUNT-1:0] r_pos_vld;

    logic [CW-1:0]  r_count;
    t_in_item       r_item;
    logic [PW-1:0]  r_pos_rd;
    logic           r_pos_hit;
    logic [TW+31:0] r_rd_data;
    logic [PW-1:0]  r_pos;        // hole of the moving entry
    logic signed [31:0] r_key;    // moving entry
    logic [TW-1:0]  r_tag;
    logic           r_mv;         // moving entry still to be placed
    logic [PW-1:0]  r_best;
    logic signed [31:0] r_bkey;
    logic [TW-1:0]  r_btag;
    logic [AW:0]    r_ci;         // children read issued
    logic           r_rd_q;       // child read lands this cycle
    logic [PW-1:0]  r_rd_addr_q;
    logic [2:0]     r_status;
    logic [TW-1:0]  r_otag;
    logic signed [31:0] r_okey;
    logic           r_out_valid;
    t_out_item      r_out;

    logic           wr_en;
    logic [PW-1:0]  wr_addr;
    logic [TW+31:0] wr_data;
    logic           rd_en;
    logic [PW-1:0]  rd_addr;
    logic           pw_en;
    logic [TW-1:0]  pw_tag;
    logic [PW-1:0]  pw_pos;
    logic [XW-1:0]  child_i;
    logic           more_child;
    logic [PW-1:0]  parent;

    assign child_i    = XW'({r_pos, 2'b00}) + XW'(r_ci) + XW'(1);
    assign more_child = (r_ci < (AW+1)'(ARITY)) && (child_i < XW'(r_count));
    assign parent     = PW'((r_pos - PW'(1)) >> AW);

    always_ff @(posedge i_clk) begin
        if (wr_en) mem_slot[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem_slot[rd_addr];
        if (pw_en) pos_mem[pw_tag] <= pw_pos;
        if (i_cmd.op == OP_LOOK) r_pos_rd <= pos_mem[i_in_item.tag];
    end

    always_comb begin
        wr_en = 1'b0; wr_addr = r_pos; wr_data = {r_tag, r_key};
        rd_en = 1'b0; rd_addr = '0;
        pw_en = 1'b0; pw_tag = r_tag; pw_pos = r_pos;
        case (i_cmd.op)
            OP_LOOK: begin
                rd_en = 1'b1; rd_addr = '0;   // root, used by pop
            end
            OP_POP: begin
                rd_en = 1'b1; rd_addr = PW'(r_count - CW'(1));
            end
            OP_DN_RD: begin
                if (more_child) begin
                    rd_en = 1'b1; rd_addr = PW'(child_i);
                end
            end
            OP_DN_SWAP: begin
                wr_en = 1'b1; wr_data = {r_btag, r_bkey};
                pw_en = 1'b1; pw_tag = r_btag;
            end
            OP_UP_RD: begin
                rd_en = 1'b1; rd_addr = parent;
            end
            OP_UP_SWAP: begin
                wr_en = 1'b1; wr_data = r_rd_data;
                pw_en = 1'b1; pw_tag = r_rd_data[TW+31:32];
            end
            // Write the moving entry at its final slot when the sift ends.
            OP_RESULT: begin
                wr_en = r_mv; pw_en = r_mv;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_pos_vld <= '0; r_out_valid <= 1'b0; r_out <= '0;
            r_rd_q <= 1'b0; r_mv <= 1'b0; r_ci <= '0;
        end else begin
            r_rd_q      <= (i_cmd.op == OP_DN_RD) && rd_en;
            r_rd_addr_q <= rd_addr;
            if (i_cmd.op != OP_RESULT && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_LOOK: begin
                    r_item <= i_in_item; r_status <= ST_OK;
                    r_otag <= '0; r_okey <= '0; r_mv <= 1'b0;
                    r_pos_hit <= r_pos_vld[i_in_item.tag];
                end
                OP_STATUS: r_status <= i_cmd.status;
                OP_INS: begin
                    r_pos <= PW'(r_count); r_key <= r_item.key; r_tag <= r_item.tag;
                    r_mv <= 1'b1; r_count <= r_count + CW'(1);
                    r_pos_vld[r_item.tag] <= 1'b1;
                end
                OP_POP: begin
                    r_otag <= r_rd_data[TW+31:32]; r_okey <= r_rd_data[31:0];
                    r_pos_vld[r_rd_data[TW+31:32]] <= 1'b0;
                    r_count <= r_count - CW'(1);
                end
                OP_POP_LD: begin
                    r_key <= r_rd_data[31:0]; r_tag <= r_rd_data[TW+31:32];
                    r_bkey <= r_rd_data[31:0]; r_btag <= r_rd_data[TW+31:32];
                    r_pos <= '0; r_best <= '0; r_ci <= '0; r_mv <= 1'b1;
                end
                OP_UPD: begin
                    r_pos <= r_pos_rd; r_best <= r_pos_rd; r_ci <= '0; r_mv <= 1'b1;
                    r_key <= r_item.key; r_tag <= r_item.tag;
                    r_bkey <= r_item.key; r_btag <= r_item.tag;
                end
                OP_DN_RD: begin
                    if (rd_en) r_ci <= r_ci + (AW+1)'(1);
                    // Keep the first strictly smallest child.
                    if (r_rd_q && $signed(r_rd_data[31:0]) < r_bkey) begin
                        r_bkey <= r_rd_data[31:0]; r_btag <= r_rd_data[TW+31:32];
                        r_best <= r_rd_addr_q;
                    end
                end
                OP_DN_SWAP: begin
                    r_pos <= r_best; r_ci <= '0;
                    r_bkey <= r_key; r_btag <= r_tag;
                end
                OP_UP_SWAP: r_pos <= parent;
                OP_RESULT: begin
                    r_out_valid <= 1'b1; r_mv <= 1'b0;
                    r_out <= '{status: r_status, out_tag: r_otag, out_key: r_okey,
                               count: r_count};
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.action   = r_item.action;
        o_stat.tag_hit  = r_pos_hit;
        o_stat.full     = (r_count >= CW'(CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.last_pop = (r_count == CW'(1));
        o_stat.rd_busy  = more_child || r_rd_q;
        o_stat.dn_stay  = (r_best == r_pos);
        o_stat.at_root  = (r_pos == '0);
        o_stat.up_stop  = !(r_key < $signed(r_rd_data[31:0]));
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INS |-> !o_stat.full) else $error("insert when full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_POP |-> !o_stat.empty) else $error("pop when empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");
endmodule

@@ src/indexed_quaternary_min_heap.sv @@
// Top level of the indexed 4-ary min-heap: controller plus datapath.
// Depends on iqmh_pkg, iqmh_ctrl, iqmh_dp.
//
//  channel  dir  handshake               payload
//  input    in   i_in_valid/o_in_ready   i_in_item  (action, tag, key)
//  output   out  o_out_valid/i_out_ready o_out_item (status, out_tag, out_key, count)
//
// One item is worked at a time. A rejected or trivial item passes only through accept,
// decide and result. Sift-up reads the parent and then compares and swaps at each level;
// sift-down makes up to four child reads through the single slot-memory read port, drains
// the last read, then decides and moves at each level, and the moving entry is written at
// its final slot with the result; a pop first loads the last entry. An update sifts down
// and then up. Synchronous active-low reset empties the heap and clears tag valid bits.
// A stalled output holds its item; the next item is taken once the result is parked.
module indexed_quaternary_min_heap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iqmh_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iqmh_pkg::t_out_item o_out_item
);
    import iqmh_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_free;

    // Sequence each item through lookup, sift and result.
    iqmh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_out_free(out_free), .i_stat(stat), .o_cmd(cmd)
    );

    // Hold heap storage and the parked result.
    iqmh_dp u_dp (
        .i_clk, .i_rst_n, .i_in_item, .i_cmd(cmd), .o_stat(stat),
        .o_out_free(out_free), .i_out_ready, .o_out_valid, .o_out_item
    );
endmodule
